[rtl/ehd_pkg.sv]
// Package for the Easter holiday date matcher.
// Field widths, mask bit positions, fixed-date table and calendar helpers.
// No dependencies.
`default_nettype none

package ehd_pkg;

  localparam int YEAR_W      = 12;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int MASK_W      = 13;
  localparam int EMON_W      = 3;
  localparam int EDAY_W      = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam int FIXED_N      = 9;
  localparam int MASK_EASTER  = 9;
  localparam int MASK_MINUS47 = 10;
  localparam int MASK_MINUS2  = 11;
  localparam int MASK_PLUS60  = 12;

  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;

  localparam month_t FIXED_MONTH [FIXED_N] = '{
    4'd1, 4'd4, 4'd5, 4'd9, 4'd10, 4'd11, 4'd11, 4'd11, 4'd12
  };
  localparam day_t FIXED_DAY [FIXED_N] = '{
    5'd1, 5'd21, 5'd1, 5'd7, 5'd12, 5'd2, 5'd15, 5'd20, 5'd25
  };

  function automatic logic [8:0] days_before(input month_t month);
    logic [8:0] r;
    case (month)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic day_t month_len(input month_t month, input logic leap);
    day_t r;
    case (month)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        r = 5'd31;
      default:                   r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/easter_holiday_date_matcher.sv]
// Easter holiday date matcher: top level, six-stage pipeline.
// Depends on ehd_pkg (widths, fixed-date table, calendar helpers).
//
// Usage:
//   A request on the in_ channel carries one Gregorian date (year, month,
//   day). For every request the out_ channel returns exactly one result:
//   a 13-bit holiday mask (nine fixed dates, Easter, Easter -47, -2, +60)
//   and the month and day of Easter in that year. Invalid dates give a
//   zero mask, with Easter still reported.
//   One request is accepted every cycle while the pipeline is not
//   stalled. The computus runs through an input register, four
//   intermediate registers (year split, epact sum and date check, epact
//   and weekday sums, weekday reduction) and the result register.
//   Each stage holds its contents while the one after it is full and
//   stalled, so when out_tready is low the pipeline fills up and in_tready
//   drops once all six registers hold requests; it rises again in the
//   cycle the result is taken.
//   Reset (rst_n low, synchronous) empties the pipeline and drops
//   out_tvalid; no configuration exists.
`default_nettype none

module easter_holiday_date_matcher (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // [11:0] query_year, [15:12] query_month, [20:16] query_day, [23:21] zero
  input  wire [ehd_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [12:0] holiday_mask, [15:13] easter_month, [20:16] easter_day, [23:21] zero
  output logic [ehd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stage valids and load enables
  logic p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r, out_v_r;
  logic p1_ld, p2_ld, p3_ld, p4_ld, p5_ld, out_ld;

  assign out_ld    = !out_v_r || out_tready;
  assign p5_ld     = !p5_v_r || out_ld;
  assign p4_ld     = !p4_v_r || p5_ld;
  assign p3_ld     = !p3_v_r || p4_ld;
  assign p2_ld     = !p2_v_r || p3_ld;
  assign p1_ld     = !p1_v_r || p2_ld;
  assign in_tready = p1_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      p5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (p1_ld)  p1_v_r  <= in_tvalid;
      if (p2_ld)  p2_v_r  <= p1_v_r;
      if (p3_ld)  p3_v_r  <= p2_v_r;
      if (p4_ld)  p4_v_r  <= p3_v_r;
      if (p5_ld)  p5_v_r  <= p4_v_r;
      if (out_ld) out_v_r <= p5_v_r;
    end
  end

  // ---------------- stage 1: input register
  logic [ehd_pkg::YEAR_W-1:0] p1_year_r;
  ehd_pkg::month_t            p1_month_r;
  ehd_pkg::day_t              p1_day_r;

  always_ff @(posedge clk) begin
    if (p1_ld) begin
      p1_year_r  <= in_tdata[11:0];
      p1_month_r <= in_tdata[15:12];
      p1_day_r   <= in_tdata[20:16];
    end
  end

  // ---------------- stage 2: split year into century, year of century, golden number
  logic [24:0] prod100;
  logic [23:0] prod19;
  logic [5:0]  cent;
  logic [7:0]  q19;
  logic [11:0] yoc_w;
  logic [11:0] gold_w;

  assign prod100 = 25'(p1_year_r) * 25'd5243;
  assign cent    = prod100[24:19];
  assign yoc_w   = p1_year_r - 12'(cent) * 12'd100;
  assign prod19  = 24'(p1_year_r) * 24'd3450;
  assign q19     = prod19[23:16];
  assign gold_w  = p1_year_r - 12'(q19) * 12'd19;

  logic [4:0]      p2_a_r;
  logic [5:0]      p2_b_r;
  logic [6:0]      p2_c_r;
  logic [1:0]      p2_ylo_r;
  ehd_pkg::month_t p2_month_r;
  ehd_pkg::day_t   p2_day_r;

  always_ff @(posedge clk) begin
    if (p2_ld) begin
      p2_a_r     <= gold_w[4:0];
      p2_b_r     <= cent;
      p2_c_r     <= yoc_w[6:0];
      p2_ylo_r   <= p1_year_r[1:0];
      p2_month_r <= p1_month_r;
      p2_day_r   <= p1_day_r;
    end
  end

  // ---------------- stage 3: epact sum, leap year, date check, ordinal day, fixed dates
  logic [3:0]                 d_q;
  logic                       f_q;
  logic [5:0]                 gv;
  logic [10:0]                prod3;
  logic [3:0]                 g_q;
  logic [9:0]                 vh_w;
  logic                       leap;
  logic                       date_ok;
  logic [8:0]                 ord;
  logic [8:0]                 qa;
  logic [ehd_pkg::FIXED_N-1:0] fixed_hit;

  assign d_q   = p2_b_r[5:2];
  assign f_q   = (p2_b_r >= 6'd17);
  assign gv    = p2_b_r - 6'(f_q) + 6'd1;
  assign prod3 = 11'(gv) * 11'd43;
  assign g_q   = prod3[10:7];
  assign vh_w  = 10'(p2_a_r) * 10'd19 + 10'(p2_b_r) - 10'(d_q) - 10'(g_q) + 10'd15;

  assign leap    = ((p2_ylo_r == 2'd0) && (p2_c_r != 7'd0)) ||
                   ((p2_c_r == 7'd0) && (p2_b_r[1:0] == 2'd0));
  assign date_ok = (p2_day_r != 5'd0) &&
                   (p2_day_r <= ehd_pkg::month_len(p2_month_r, leap));
  assign ord     = ehd_pkg::days_before(p2_month_r) + 9'(p2_day_r) +
                   9'((p2_month_r > 4'd2) && leap);
  // Easter ordinal is s - 33 + leap; fold the offset into the query side
  assign qa      = ord + 9'd33 - 9'(leap);

  always_comb begin
    for (int n = 0; n < ehd_pkg::FIXED_N; n++) begin
      fixed_hit[n] = (p2_month_r == ehd_pkg::FIXED_MONTH[n]) &&
                     (p2_day_r == ehd_pkg::FIXED_DAY[n]);
    end
  end

  logic [4:0]                  p3_a_r;
  logic [1:0]                  p3_e_r;
  logic [4:0]                  p3_i_r;
  logic [1:0]                  p3_k_r;
  logic [8:0]                  p3_vh_r;
  logic [8:0]                  p3_qa_r;
  logic [ehd_pkg::FIXED_N-1:0] p3_fixed_r;
  logic                        p3_ok_r;

  always_ff @(posedge clk) begin
    if (p3_ld) begin
      p3_a_r     <= p2_a_r;
      p3_e_r     <= p2_b_r[1:0];
      p3_i_r     <= p2_c_r[6:2];
      p3_k_r     <= p2_c_r[1:0];
      p3_vh_r    <= vh_w[8:0];
      p3_qa_r    <= qa;
      p3_fixed_r <= fixed_hit;
      p3_ok_r    <= date_ok;
    end
  end

  // ---------------- stage 4: epact mod 30, weekday sum
  logic [19:0] prod30;
  logic [3:0]  q30;
  logic [8:0]  h_w;
  logic [7:0]  vl_w;

  assign prod30 = 20'(p3_vh_r) * 20'd2185;
  assign q30    = prod30[19:16];
  assign h_w    = p3_vh_r - 9'(q30) * 9'd30;
  assign vl_w   = 8'd32 + 8'({p3_e_r, 1'b0}) + 8'({p3_i_r, 1'b0}) -
                  8'(h_w[4:0]) - 8'(p3_k_r);

  logic [4:0]                  p4_a_r;
  logic [4:0]                  p4_h_r;
  logic [6:0]                  p4_vl_r;
  logic [8:0]                  p4_qa_r;
  logic [ehd_pkg::FIXED_N-1:0] p4_fixed_r;
  logic                        p4_ok_r;

  always_ff @(posedge clk) begin
    if (p4_ld) begin
      p4_a_r     <= p3_a_r;
      p4_h_r     <= h_w[4:0];
      p4_vl_r    <= vl_w[6:0];
      p4_qa_r    <= p3_qa_r;
      p4_fixed_r <= p3_fixed_r;
      p4_ok_r    <= p3_ok_r;
    end
  end

  // ---------------- stage 5: weekday mod 7
  logic [14:0] prod7;
  logic [3:0]  q7;
  logic [6:0]  l_w;

  assign prod7 = 15'(p4_vl_r) * 15'd293;
  assign q7    = prod7[14:11];
  assign l_w   = p4_vl_r - 7'(q7) * 7'd7;

  logic [4:0]                  p5_a_r;
  logic [4:0]                  p5_h_r;
  logic [2:0]                  p5_l_r;
  logic [8:0]                  p5_qa_r;
  logic [ehd_pkg::FIXED_N-1:0] p5_fixed_r;
  logic                        p5_ok_r;

  always_ff @(posedge clk) begin
    if (p5_ld) begin
      p5_a_r     <= p4_a_r;
      p5_h_r     <= p4_h_r;
      p5_l_r     <= l_w[2:0];
      p5_qa_r    <= p4_qa_r;
      p5_fixed_r <= p4_fixed_r;
      p5_ok_r    <= p4_ok_r;
    end
  end

  // ---------------- result: Easter date and offset matches
  logic [9:0]                   mv;
  logic                         m_q;
  logic [7:0]                   s_w;
  logic                         apr;
  logic [ehd_pkg::EMON_W-1:0]   em;
  logic [7:0]                   ed_w;
  logic [9:0]                   s_ext;
  logic [9:0]                   qa_ext;
  logic [ehd_pkg::MASK_W-1:0]   mask;

  assign mv     = 10'(p5_a_r) + 10'(p5_h_r) * 10'd11 + 10'(p5_l_r) * 10'd22;
  assign m_q    = (mv >= 10'd451);
  assign s_w    = 8'(p5_h_r) + 8'(p5_l_r) + 8'd114 - (m_q ? 8'd7 : 8'd0);
  assign apr    = (s_w >= 8'd124);
  assign em     = apr ? 3'd4 : 3'd3;
  assign ed_w   = apr ? (s_w - 8'd123) : (s_w - 8'd92);
  assign s_ext  = 10'(s_w);
  assign qa_ext = 10'(p5_qa_r);

  always_comb begin
    mask = '0;
    if (p5_ok_r) begin
      mask[ehd_pkg::FIXED_N-1:0]  = p5_fixed_r;
      mask[ehd_pkg::MASK_EASTER]  = (s_ext == qa_ext);
      mask[ehd_pkg::MASK_MINUS47] = (s_ext == qa_ext + 10'd47);
      mask[ehd_pkg::MASK_MINUS2]  = (s_ext == qa_ext + 10'd2);
      mask[ehd_pkg::MASK_PLUS60]  = (s_ext + 10'd60 == qa_ext);
    end
  end

  logic [ehd_pkg::MASK_W-1:0] out_mask_r;
  logic [ehd_pkg::EMON_W-1:0] out_em_r;
  logic [ehd_pkg::EDAY_W-1:0] out_ed_r;

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_mask_r <= mask;
      out_em_r   <= em;
      out_ed_r   <= ed_w[4:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_ed_r, out_em_r, out_mask_r};

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for easter_holiday_date_matcher: a queue-fed request driver, a result monitor
// and an in-bench holiday predictor (computus, fixed dates, Easter offsets).
// Depends on ehd_pkg for port widths and mask bit positions.

module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_DATES   = 900;

  typedef struct packed {
    logic [ehd_pkg::DAY_W-1:0]   day;
    logic [ehd_pkg::MONTH_W-1:0] month;
    logic [ehd_pkg::YEAR_W-1:0]  year;
  } date_req_t;

  typedef struct packed {
    logic [ehd_pkg::EDAY_W-1:0] day;
    logic [ehd_pkg::EMON_W-1:0] month;
  } easter_t;

  typedef struct packed {
    logic [ehd_pkg::EDAY_W-1:0] eday;
    logic [ehd_pkg::EMON_W-1:0] emon;
    logic [ehd_pkg::MASK_W-1:0] mask;
  } holiday_result_t;

  localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int HOLIDAY_MON [9] = '{1, 4, 5, 9, 10, 11, 11, 11, 12};
  localparam int HOLIDAY_DAY [9] = '{1, 21, 1, 7, 12, 2, 15, 20, 25};

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ehd_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ehd_pkg::OUT_TDATA_W-1:0] out_tdata;

  date_req_t pending_dates[$];
  holiday_result_t expected_results[$];
  holiday_result_t got_result, want_result;
  int mismatches = 0;
  int idle_cycles = 0;
  int in_gap = 0, in_burst = 0;
  int out_stall = 0, out_burst = 0;

  easter_holiday_date_matcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic bit is_leap(int y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int month_days(int y, int m);
    if (m < 1 || m > 12) return 0;
    if (m == 2 && is_leap(y)) return 29;
    return MONTH_DAYS[m-1];
  endfunction

  function automatic int day_of_year(int y, int m, int d);
    int ord;
    ord = d;
    for (int n = 1; n < m; n++) ord += month_days(y, n);
    return ord;
  endfunction

  function automatic date_req_t date_at(int y, int ord);
    date_req_t r;
    int m;
    m = 1;
    while (ord > month_days(y, m)) begin
      ord -= month_days(y, m);
      m++;
    end
    r.year = ehd_pkg::YEAR_W'(y);
    r.month = ehd_pkg::MONTH_W'(m);
    r.day = ehd_pkg::DAY_W'(ord);
    return r;
  endfunction

  function automatic easter_t easter_in(int y);
    easter_t e;
    int a, b, c, d, k4, f, g, h, i, k, l, m, s;
    a = y % 19;
    b = y / 100;
    c = y % 100;
    d = b / 4;
    k4 = b % 4;
    f = (b + 8) / 25;
    g = (b - f + 1) / 3;
    h = (19 * a + b - d - g + 15) % 30;
    i = c / 4;
    k = c % 4;
    l = (32 + 2 * k4 + 2 * i - h - k) % 7;
    m = (a + 11 * h + 22 * l) / 451;
    s = h + l - 7 * m + 114;
    e.month = ehd_pkg::EMON_W'(s / 31);
    e.day = ehd_pkg::EDAY_W'(s % 31 + 1);
    return e;
  endfunction

  function automatic holiday_result_t predict_holidays(date_req_t q);
    holiday_result_t r;
    easter_t e;
    int y, m, d, qo, eo;
    y = q.year;
    m = q.month;
    d = q.day;
    e = easter_in(y);
    r.mask = '0;
    r.emon = e.month;
    r.eday = e.day;
    if (m >= 1 && m <= 12 && d >= 1 && d <= month_days(y, m)) begin
      qo = day_of_year(y, m, d);
      eo = day_of_year(y, e.month, e.day);
      for (int n = 0; n < ehd_pkg::FIXED_N; n++)
        if (HOLIDAY_MON[n] == m && HOLIDAY_DAY[n] == d) r.mask[n] = 1'b1;
      r.mask[ehd_pkg::MASK_EASTER] = (qo == eo);
      r.mask[ehd_pkg::MASK_MINUS47] = (qo == eo - 47);
      r.mask[ehd_pkg::MASK_MINUS2] = (qo == eo - 2);
      r.mask[ehd_pkg::MASK_PLUS60] = (qo == eo + 60);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int random_year();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1583, 4095);
    return $urandom_range(0, 1582);
  endfunction

  task automatic queue_date(int y, int m, int d);
    date_req_t r;
    r.year = ehd_pkg::YEAR_W'(y);
    r.month = ehd_pkg::MONTH_W'(m);
    r.day = ehd_pkg::DAY_W'(d);
    pending_dates.push_back(r);
  endtask

  // kind is a holiday mask bit position
  task automatic queue_holiday(int y, int kind);
    easter_t e;
    int eo;
    if (kind < ehd_pkg::FIXED_N) begin
      queue_date(y, HOLIDAY_MON[kind], HOLIDAY_DAY[kind]);
    end else begin
      e = easter_in(y);
      eo = day_of_year(y, e.month, e.day);
      case (kind)
        ehd_pkg::MASK_MINUS47: eo -= 47;
        ehd_pkg::MASK_MINUS2:  eo -= 2;
        ehd_pkg::MASK_PLUS60:  eo += 60;
        default:               eo += 0;
      endcase
      pending_dates.push_back(date_at(y, eo));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    int y, m, r;
    queue_date(0, 1, 1);
    queue_date(4095, 12, 31);
    for (int n = 0; n < ehd_pkg::FIXED_N; n++) queue_holiday(2023, n);
    queue_holiday(2024, ehd_pkg::MASK_EASTER);
    queue_holiday(2024, ehd_pkg::MASK_MINUS47);
    queue_holiday(2024, ehd_pkg::MASK_MINUS2);
    queue_holiday(2024, ehd_pkg::MASK_PLUS60);
    queue_holiday(2019, ehd_pkg::MASK_EASTER);
    queue_holiday(1943, ehd_pkg::MASK_EASTER);
    queue_holiday(1818, ehd_pkg::MASK_EASTER);
    queue_holiday(1582, ehd_pkg::MASK_PLUS60);
    queue_date(2000, 2, 29);
    queue_date(1900, 2, 29);
    queue_date(2024, 4, 31);
    queue_date(2024, 0, 5);
    queue_date(2024, 1, 0);
    queue_date(4095, 15, 31);
    queue_date(1, 13, 1);

    for (int n = 0; n < RANDOM_DATES; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        queue_holiday(random_year(), $urandom_range(0, ehd_pkg::MASK_W - 1));
      end else if (r < 75) begin
        y = random_year();
        m = $urandom_range(1, 12);
        queue_date(y, m, $urandom_range(1, month_days(y, m)));
      end else begin
        queue_date($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
      end
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (pending_dates.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_holidays(date_req_t'(in_tdata[20:0])));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_dates.size() != 0) begin
          in_tdata <= ehd_pkg::IN_TDATA_W'(pending_dates.pop_front());
          in_tvalid <= 1'b1;
          if (in_burst > 0) begin
            in_burst <= in_burst - 1;
          end else begin
            in_gap <= pick_gap();
            if ($urandom_range(0, 99) < 4) in_burst <= $urandom_range(20, 80);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_burst > 0) begin
        out_burst <= out_burst - 1;
      end else begin
        out_stall <= pick_gap();
        if ($urandom_range(0, 99) < 4) out_burst <= $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result.mask = out_tdata[12:0];
      got_result.emon = out_tdata[15:13];
      got_result.eday = out_tdata[20:16];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual mask %h easter %0d/%0d", $time,
                 got_result.mask, got_result.emon, got_result.eday);
        mismatches++;
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.mask !== want_result.mask) begin
          $display("%0t: holiday_mask expected %h actual %h", $time,
                   want_result.mask, got_result.mask);
          mismatches++;
        end
        if (got_result.emon !== want_result.emon) begin
          $display("%0t: easter_month expected %0d actual %0d", $time,
                   want_result.emon, got_result.emon);
          mismatches++;
        end
        if (got_result.eday !== want_result.eday) begin
          $display("%0t: easter_day expected %0d actual %0d", $time,
                   want_result.eday, got_result.eday);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no request or result moved", $time);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
